[src/assert_macros.svh]
// Assertion macros used by the RTL.
// IMP checks the consequent in the same cycle, NXT checks it in the following cycle.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SJF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sjf assertion failed");

`define SJF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sjf assertion failed");

`else

`define SJF_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define SJF_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/sjf_pkg.sv]
package sjf_pkg;

    // default number of ready queue entries
    localparam int READY_DEPTH_DEF = 16;

    localparam int PID_W   = 16;
    localparam int TIME_W  = 32;
    localparam int TICK_W  = 16;
    localparam int COUNT_W = 5;

    // one queued job as stored in the ready queue memory
    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] elapsed;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_TICK,
        S_SCAN,
        S_PICK,
        S_SHIFT,
        S_OUT
    } t_state;

    // remaining run time, floored at zero
    function automatic logic [TIME_W-1:0] f_remaining(t_job job);
        logic [TIME_W-1:0] rem;
        rem = (job.burst > job.elapsed) ? (job.burst - job.elapsed) : '0;
        return rem;
    endfunction

endpackage

[src/sjf_queue_mem.sv]
module sjf_queue_mem #(
    parameter int DEPTH = sjf_pkg::READY_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  sjf_pkg::t_job            i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output sjf_pkg::t_job            o_rdata
);

    sjf_pkg::t_job r_mem [DEPTH];
    sjf_pkg::t_job r_rdata;

    // write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/sjf_ready_queue_scheduler_top.sv]
// Channel  Direction  Handshake                 Beat contents
// in       input      i_in_valid / o_in_ready    op, job_pid, burst_ms, start_elapsed_ms, now_ms
// out      output     o_out_valid / i_out_ready  done_*, cpu_*, ready_count, job_dropped
// cfg      input      i_cfg_we                   tick_length_ms (16 bit)
//
// An enqueue passes from acceptance through the enqueue step to the output step. A tick goes
// through the tick step to the output step when no selection is needed; when it selects among
// the queued jobs it scans, picks and shifts before the output step: one memory read port scans
// the queue one entry per cycle, then the same port moves the later entries down one per cycle.
// Reset is synchronous, active low; the queue memory needs no clearing pass.
// A result waiting on a stalled output holds the block in its output step.
`include "assert_macros.svh"

module sjf_ready_queue_scheduler_top #(
    parameter int READY_DEPTH = sjf_pkg::READY_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [sjf_pkg::TICK_W-1:0]  i_cfg_data,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_op,
    input  logic [sjf_pkg::PID_W-1:0]   i_job_pid,
    input  logic [sjf_pkg::TIME_W-1:0]  i_burst_ms,
    input  logic [sjf_pkg::TIME_W-1:0]  i_start_elapsed_ms,
    input  logic [sjf_pkg::TIME_W-1:0]  i_now_ms,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_done_valid,
    output logic [sjf_pkg::PID_W-1:0]   o_done_pid,
    output logic [sjf_pkg::TIME_W-1:0]  o_done_time_ms,
    output logic                        o_cpu_busy,
    output logic [sjf_pkg::PID_W-1:0]   o_cpu_pid,
    output logic [sjf_pkg::COUNT_W-1:0] o_ready_count,
    output logic                        o_job_dropped
);

    localparam int AW = $clog2(READY_DEPTH);
    localparam int LW = $clog2(READY_DEPTH + 1);
    localparam logic [LW-1:0] LEN_FULL = LW'(READY_DEPTH);

    sjf_pkg::t_state r_state, n_state;

    logic [sjf_pkg::TICK_W-1:0] r_tick_len;

    // latched item
    sjf_pkg::t_job               r_job;
    logic [sjf_pkg::TIME_W-1:0]  r_now;

    // running job
    logic                        r_run_vld;
    sjf_pkg::t_job               r_run;

    logic [LW-1:0]               r_len;

    // scan and shift pipeline
    logic [LW-1:0]               r_ptr;
    logic                        r_p1_vld;
    logic [AW-1:0]               r_p1_idx;
    logic                        r_p2_vld;
    logic [AW-1:0]               r_p2_idx;
    logic [sjf_pkg::TIME_W-1:0]  r_p2_rem;
    sjf_pkg::t_job               r_p2_job;
    logic                        r_have;
    logic [AW-1:0]               r_best_idx;
    logic [sjf_pkg::TIME_W-1:0]  r_best_rem;
    sjf_pkg::t_job               r_best_job;

    // result under construction
    logic                        r_res_done;
    logic [sjf_pkg::PID_W-1:0]   r_res_done_pid;
    logic [sjf_pkg::TIME_W-1:0]  r_res_done_time;
    logic                        r_res_drop;

    // output register
    logic                        r_out_valid;
    logic                        r_o_done;
    logic [sjf_pkg::PID_W-1:0]   r_o_done_pid;
    logic [sjf_pkg::TIME_W-1:0]  r_o_done_time;
    logic                        r_o_busy;
    logic [sjf_pkg::PID_W-1:0]   r_o_cpu_pid;
    logic [sjf_pkg::COUNT_W-1:0] r_o_count;
    logic                        r_o_drop;

    // memory port
    logic                        w_mem_we;
    logic [AW-1:0]               w_mem_waddr;
    sjf_pkg::t_job               w_mem_wdata;
    logic                        w_mem_re;
    logic [AW-1:0]               w_mem_raddr;
    sjf_pkg::t_job               w_mem_rdata;

    logic                        w_accept;
    logic [sjf_pkg::TIME_W:0]    w_sum;
    logic [sjf_pkg::TIME_W-1:0]  w_sat;
    logic                        w_fin;
    logic                        w_need_pick;
    logic                        w_issue;
    logic                        w_out_load;

    sjf_queue_mem #(
        .DEPTH (READY_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    assign o_in_ready = (r_state == sjf_pkg::S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // advance running job by one tick, saturating
    assign w_sum = {1'b0, r_run.elapsed} + (sjf_pkg::TIME_W + 1)'(r_tick_len);
    assign w_sat = w_sum[sjf_pkg::TIME_W] ? '1 : w_sum[sjf_pkg::TIME_W-1:0];
    assign w_fin = r_run_vld && (w_sat >= r_run.burst);
    assign w_need_pick = (r_len != '0) && (!r_run_vld || w_fin);

    assign w_issue    = (r_ptr < r_len);
    assign w_out_load = (r_state == sjf_pkg::S_OUT) && (!r_out_valid || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sjf_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = i_op ? sjf_pkg::S_ENQ : sjf_pkg::S_TICK;
                end
            end
            sjf_pkg::S_ENQ: begin
                n_state = sjf_pkg::S_OUT;
            end
            sjf_pkg::S_TICK: begin
                n_state = w_need_pick ? sjf_pkg::S_SCAN : sjf_pkg::S_OUT;
            end
            sjf_pkg::S_SCAN: begin
                if (!w_issue && !r_p1_vld && !r_p2_vld) begin
                    n_state = sjf_pkg::S_PICK;
                end
            end
            sjf_pkg::S_PICK: begin
                n_state = sjf_pkg::S_SHIFT;
            end
            sjf_pkg::S_SHIFT: begin
                if (!w_issue && !r_p1_vld) begin
                    n_state = sjf_pkg::S_OUT;
                end
            end
            sjf_pkg::S_OUT: begin
                if (w_out_load) begin
                    n_state = sjf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sjf_pkg::S_IDLE;
            end
        endcase
    end

    // memory controls
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_len[AW-1:0];
        w_mem_wdata = r_job;
        w_mem_re    = 1'b0;
        w_mem_raddr = r_ptr[AW-1:0];
        case (r_state)
            sjf_pkg::S_ENQ: begin
                w_mem_we = (r_len < LEN_FULL);
            end
            sjf_pkg::S_SCAN: begin
                w_mem_re = w_issue;
            end
            sjf_pkg::S_SHIFT: begin
                w_mem_re    = w_issue;
                w_mem_we    = r_p1_vld;
                w_mem_waddr = r_p1_idx - AW'(1);
                w_mem_wdata = w_mem_rdata;
            end
            default: begin
                w_mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sjf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_len <= sjf_pkg::TICK_W'(1);
        end else if (i_cfg_we) begin
            r_tick_len <= i_cfg_data;
        end
    end

    // latch item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job.pid     <= i_job_pid;
            r_job.burst   <= i_burst_ms;
            r_job.elapsed <= i_start_elapsed_ms;
            r_now     <= i_now_ms;
        end
    end

    // scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_vld  <= 1'b0;
            r_len      <= '0;
            r_p1_vld   <= 1'b0;
            r_p2_vld   <= 1'b0;
            r_have     <= 1'b0;
            r_res_done <= 1'b0;
            r_res_drop <= 1'b0;
        end else begin
            case (r_state)
                sjf_pkg::S_IDLE: begin
                    if (w_accept) begin
                        r_res_done      <= 1'b0;
                        r_res_done_pid  <= '0;
                        r_res_done_time <= '0;
                        r_res_drop      <= 1'b0;
                    end
                end
                sjf_pkg::S_ENQ: begin
                    if (r_len < LEN_FULL) begin
                        r_len <= r_len + LW'(1);
                    end else begin
                        r_res_drop <= 1'b1;
                    end
                end
                sjf_pkg::S_TICK: begin
                    if (r_run_vld) begin
                        r_run.elapsed <= w_sat;
                    end
                    if (w_fin) begin
                        r_res_done      <= 1'b1;
                        r_res_done_pid  <= r_run.pid;
                        r_res_done_time <= r_now;
                        r_run_vld       <= 1'b0;
                    end
                    r_ptr    <= '0;
                    r_p1_vld <= 1'b0;
                    r_p2_vld <= 1'b0;
                    r_have   <= 1'b0;
                end
                sjf_pkg::S_SCAN: begin
                    // issue read
                    if (w_issue) begin
                        r_ptr <= r_ptr + LW'(1);
                    end
                    r_p1_vld <= w_issue;
                    r_p1_idx <= r_ptr[AW-1:0];
                    // remaining time of the entry just read
                    r_p2_vld <= r_p1_vld;
                    r_p2_idx <= r_p1_idx;
                    r_p2_rem <= sjf_pkg::f_remaining(w_mem_rdata);
                    r_p2_job <= w_mem_rdata;
                    // keep the earliest strict minimum
                    if (r_p2_vld && (!r_have || (r_p2_rem < r_best_rem))) begin
                        r_have     <= 1'b1;
                        r_best_idx <= r_p2_idx;
                        r_best_rem <= r_p2_rem;
                        r_best_job <= r_p2_job;
                    end
                end
                sjf_pkg::S_PICK: begin
                    r_run_vld <= 1'b1;
                    r_run     <= r_best_job;
                    r_ptr     <= LW'(r_best_idx) + LW'(1);
                    r_p1_vld  <= 1'b0;
                end
                sjf_pkg::S_SHIFT: begin
                    // move later entries down by one
                    if (w_issue) begin
                        r_ptr <= r_ptr + LW'(1);
                    end
                    r_p1_vld <= w_issue;
                    r_p1_idx <= r_ptr[AW-1:0];
                    if (!w_issue && !r_p1_vld) begin
                        r_len <= r_len - LW'(1);
                    end
                end
                default: begin
                    r_p1_vld <= 1'b0;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_done      <= r_res_done;
            r_o_done_pid  <= r_res_done_pid;
            r_o_done_time <= r_res_done_time;
            r_o_busy      <= r_run_vld;
            r_o_cpu_pid   <= r_run_vld ? r_run.pid : '0;
            r_o_count     <= sjf_pkg::COUNT_W'(r_len);
            r_o_drop      <= r_res_drop;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_done_valid   = r_o_done;
    assign o_done_pid     = r_o_done_pid;
    assign o_done_time_ms = r_o_done_time;
    assign o_cpu_busy     = r_o_busy;
    assign o_cpu_pid      = r_o_cpu_pid;
    assign o_ready_count  = r_o_count;
    assign o_job_dropped  = r_o_drop;

    // queue never holds more than its depth
    `SJF_ASSERT_IMP(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= LEN_FULL)
    // an enqueue into a full queue flags the drop
    `SJF_ASSERT_NXT(a_full_drop, i_clk, i_rst_n,
        (r_state == sjf_pkg::S_ENQ) && (r_len == LEN_FULL), r_res_drop)
    // an enqueue never reports a completion
    `SJF_ASSERT_NXT(a_enq_no_done, i_clk, i_rst_n, r_state == sjf_pkg::S_ENQ, !r_res_done)
    // a selection leaves the CPU busy
    `SJF_ASSERT_NXT(a_pick_busy, i_clk, i_rst_n, r_state == sjf_pkg::S_PICK, r_run_vld)
    // compaction moves only entries inside the occupied queue, never the head entry
    `SJF_ASSERT_IMP(a_shift_addr, i_clk, i_rst_n,
        (r_state == sjf_pkg::S_SHIFT) && w_mem_we,
        (LW'(r_p1_idx) < r_len) && (r_p1_idx != '0))

endmodule
